FILE: rtl/core/ecq_pkg.sv
// shared types and codes for the event calendar queue
`default_nettype none

package ecq_pkg;

   localparam int TIME_W = 32;
   localparam int LAT_W  = 20;
   localparam int PRIO_W = 8;
   localparam int DEV_W  = 4;
   localparam int OP_W   = 3;
   localparam int ADDR_W = 48;
   localparam int LEN_W  = 16;

   // command codes
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_POP    = 1'b1;

   typedef enum logic [1:0] {
      STATUS_POPPED   = 2'd0,
      STATUS_EMPTY    = 2'd1,
      STATUS_INSERTED = 2'd2,
      STATUS_DROPPED  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT
   } state_type;

   // one stored event
   typedef struct packed {
      logic [TIME_W-1:0] due_time;
      logic [PRIO_W-1:0] prio;
      logic [DEV_W-1:0]  device;
      logic [OP_W-1:0]   operation;
      logic [ADDR_W-1:0] address;
      logic [LEN_W-1:0]  length;
   } slot_type;

endpackage

`default_nettype wire

FILE: rtl/core/event_calendar_queue.sv
// event calendar queue: pending-event store with earliest-due-time pop
`default_nettype none

// Pending-event calendar. A transaction is taken when start is high and busy is low.
// An insert stores the event due at current time plus latency and answers in the next
// cycle with status inserted, or dropped when all QUEUE_DEPTH slots hold events.
// A pop on an empty calendar answers in the next cycle with status empty. A pop of n
// stored events walks the slot memory through its single read port, one slot per
// cycle, to find the earliest due time, lower priority value winning ties and the
// older event winning full ties; it then closes the gap by moving each later slot
// down by one, one slot per cycle. The result appears in the cycle after the last of
// those steps; busy stays high meanwhile. Current time moves to the popped event's
// due time. Each result is shown for exactly one cycle with rsp_valid high and
// cannot be held off by the receiver; fields other than status are zero except
// on a successful pop. There is no clearing pass after reset: slots may be read
// before they hold an event, but only the contents of occupied slots are used.
module event_calendar_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             start,
   output logic                            busy,
   input  wire                             req_command,
   input  wire  [ecq_pkg::LAT_W-1:0]       req_latency,
   input  wire  [ecq_pkg::PRIO_W-1:0]      req_priority_req,
   input  wire  [ecq_pkg::DEV_W-1:0]       req_device_id,
   input  wire  [ecq_pkg::OP_W-1:0]        req_operation,
   input  wire  [ecq_pkg::ADDR_W-1:0]      req_address,
   input  wire  [ecq_pkg::LEN_W-1:0]       req_length,
   output logic                            rsp_valid,
   output ecq_pkg::status_type             rsp_status,
   output logic [ecq_pkg::TIME_W-1:0]      rsp_event_time,
   output logic [ecq_pkg::PRIO_W-1:0]      rsp_event_priority,
   output logic [ecq_pkg::DEV_W-1:0]       rsp_event_device,
   output logic [ecq_pkg::OP_W-1:0]        rsp_event_operation,
   output logic [ecq_pkg::ADDR_W-1:0]      rsp_event_address,
   output logic [ecq_pkg::LEN_W-1:0]       rsp_event_length
);
   import ecq_pkg::*;

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   // slot memory, occupied slots kept compacted in insertion order
   slot_type                slot_mem [QUEUE_DEPTH];

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        occ_ff;
   logic [TIME_W-1:0]       cur_time_ff;
   logic [IDX_W-1:0]        idx_ff;       // scan: slot held in rd_data_ff; shift: target slot
   logic [IDX_W-1:0]        best_idx_ff;
   slot_type                best_ff;
   slot_type                rd_data_ff;
   logic                    rsp_valid_ff;
   status_type              rsp_status_ff;
   slot_type                rsp_slot_ff;

   // control and datapath strobes
   logic                    accept;
   logic                    is_pop;
   logic                    full;
   logic                    empty;
   logic [CNT_W-1:0]        occ_last;
   logic [CNT_W-1:0]        occ_last2;
   logic                    take;
   slot_type                best_sel;
   logic [IDX_W-1:0]        best_idx_sel;
   logic                    scan_last;
   logic                    need_shift;
   logic                    shift_last;
   logic                    pop_done;
   logic                    imm_rsp;
   logic                    ins_ok;
   logic [IDX_W-1:0]        rd_addr;
   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   slot_type                wr_data;
   slot_type                new_slot;
   slot_type                pop_slot;

   assign accept    = start && (state_ff == ST_IDLE);
   assign is_pop    = (req_command == CMD_POP);
   assign full      = (occ_ff == CNT_W'(QUEUE_DEPTH));
   assign empty     = (occ_ff == '0);
   assign occ_last  = occ_ff - CNT_W'(1);
   assign occ_last2 = occ_ff - CNT_W'(2);
   assign ins_ok    = accept && !is_pop && !full;
   assign imm_rsp   = accept && (!is_pop || empty);

   // compare unit for the scan: running minimum over (due time, priority)
   always_comb begin
      take = (idx_ff == '0)
          || (rd_data_ff.due_time < best_ff.due_time)
          || ((rd_data_ff.due_time == best_ff.due_time) && (rd_data_ff.prio < best_ff.prio));
      best_sel     = take ? rd_data_ff : best_ff;
      best_idx_sel = take ? idx_ff : best_idx_ff;
   end

   assign scan_last  = (CNT_W'(idx_ff) == occ_last);
   assign need_shift = (CNT_W'(best_idx_sel) != occ_last);
   assign shift_last = (CNT_W'(idx_ff) == occ_last2);

   // event built from the request
   always_comb begin
      new_slot.due_time  = cur_time_ff + TIME_W'(req_latency);
      new_slot.prio      = req_priority_req;
      new_slot.device    = req_device_id;
      new_slot.operation = req_operation;
      new_slot.address   = req_address;
      new_slot.length    = req_length;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && is_pop && !empty) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_last) state_in = need_shift ? ST_SHIFT : ST_IDLE;
         end
         ST_SHIFT: begin
            if (shift_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      busy     = 1'b1;
      rd_addr  = '0;
      wr_en    = 1'b0;
      wr_addr  = occ_ff[IDX_W-1:0];
      wr_data  = new_slot;
      pop_done = 1'b0;
      pop_slot = best_ff;
      unique case (state_ff)
         ST_IDLE: begin
            busy    = 1'b0;
            rd_addr = '0;
            wr_en   = ins_ok;
         end
         ST_SCAN: begin
            // on the last scan step prefetch the slot after the winner for the shift
            rd_addr  = scan_last ? IDX_W'(best_idx_sel + 1'b1) : IDX_W'(idx_ff + 1'b1);
            pop_done = scan_last && !need_shift;
            pop_slot = best_sel;
         end
         ST_SHIFT: begin
            rd_addr  = IDX_W'({1'b0, idx_ff} + (IDX_W + 1)'(2));
            wr_en    = 1'b1;
            wr_addr  = idx_ff;
            wr_data  = rd_data_ff;
            pop_done = shift_last;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   // slot memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) slot_mem[wr_addr] <= wr_data;
      rd_data_ff <= slot_mem[rd_addr];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         cur_time_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= imm_rsp || pop_done;
         if (ins_ok) occ_ff <= occ_ff + CNT_W'(1);
         else if (pop_done) occ_ff <= occ_last;
         if (pop_done) cur_time_ff <= pop_slot.due_time;
      end
   end

   // scan and shift counters, result payload
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE:  idx_ff <= '0;
         ST_SCAN:  idx_ff <= scan_last ? best_idx_sel : IDX_W'(idx_ff + 1'b1);
         ST_SHIFT: idx_ff <= IDX_W'(idx_ff + 1'b1);
         default:  idx_ff <= '0;
      endcase
      if (state_ff == ST_SCAN) begin
         best_ff     <= best_sel;
         best_idx_ff <= best_idx_sel;
      end
      if (pop_done) begin
         rsp_status_ff <= STATUS_POPPED;
         rsp_slot_ff   <= pop_slot;
      end else if (imm_rsp) begin
         rsp_slot_ff <= '0;
         priority if (is_pop) rsp_status_ff <= STATUS_EMPTY;
         else if (full)       rsp_status_ff <= STATUS_DROPPED;
         else                 rsp_status_ff <= STATUS_INSERTED;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_event_time      = rsp_slot_ff.due_time;
   assign rsp_event_priority  = rsp_slot_ff.prio;
   assign rsp_event_device    = rsp_slot_ff.device;
   assign rsp_event_operation = rsp_slot_ff.operation;
   assign rsp_event_address   = rsp_slot_ff.address;
   assign rsp_event_length    = rsp_slot_ff.length;

   // occupancy never passes the slot count
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("occupancy above queue depth");

   // a pop in progress always has at least one event to hand out
   a_busy_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (occ_ff != '0))
      else $error("pop sequence running on an empty calendar");

   // an insert or empty pop answers on the next cycle
   a_imm_rsp: assert property (@(posedge clock) disable iff (reset)
      imm_rsp |=> rsp_valid)
      else $error("missing immediate response");

   // shifting only writes slots below the last occupied one
   a_shift_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) |-> (CNT_W'(idx_ff) < occ_last))
      else $error("shift target outside occupied range");

   // a popped event's time becomes current time
   a_time_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_POPPED)) |-> (rsp_event_time == cur_time_ff))
      else $error("current time not moved to popped event");

endmodule

`default_nettype wire
